// ----- src/assert_macros.svh -----
// Assertion helper macros for the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check, disabled while the active-low reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error(msg);
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error(msg);
`endif

// ----- src/dfios_pkg.sv -----
// ----------------------------------------------------------------------------
// dfios_pkg
// Shared types and constants for the deadline FIFO I/O scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package dfios_pkg;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned EXP_W = 31;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned NCLS = 4;
    localparam int unsigned CFG_IDX_W = 3;

    // class codes: {sync, write}
    localparam logic [1:0] CLS_ASYNC_READ = 2'd0;
    localparam logic [1:0] CLS_ASYNC_WRITE = 2'd1;
    localparam logic [1:0] CLS_SYNC_READ = 2'd2;
    localparam logic [1:0] CLS_SYNC_WRITE = 2'd3;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_DISPATCHED = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SR_EXP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SW_EXP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AR_EXP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AW_EXP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WSTARVE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ARSTARVE = 3'd6;

    typedef enum logic [1:0] {
        t_idle = 2'd0,
        t_exec = 2'd1,
        t_out  = 2'd2
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture input item
        logic exec;    // heads are read; decide and update
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_dispatch;
    } t_stat;
endpackage
`default_nettype wire

// ----- src/dfios_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfios_ctrl
// Item sequencer: capture, execute, then hold result until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dfios_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_fire,
    input  wire                  i_out_ready,
    input  wire dfios_pkg::t_stat i_stat,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output dfios_pkg::t_cmd      o_cmd
);
    dfios_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dfios_pkg::t_idle;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd = '0;
        unique case (r_state)
            dfios_pkg::t_idle: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = dfios_pkg::t_exec;
                end
            end
            dfios_pkg::t_exec: begin
                o_cmd.exec = 1'b1;
                n_state = dfios_pkg::t_out;
            end
            dfios_pkg::t_out: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_fire) begin
                        o_cmd.load = 1'b1;
                        n_state = dfios_pkg::t_exec;
                    end else begin
                        n_state = dfios_pkg::t_idle;
                    end
                end
            end
            default: n_state = dfios_pkg::t_idle;
        endcase
    end

    `ASSERT_NEXT(a_load_exec, i_clk, i_rst_n, o_cmd.load, o_cmd.exec, "exec must follow load")
    `ASSERT_NEXT(a_exec_out, i_clk, i_rst_n, o_cmd.exec, o_out_valid, "result after exec")
    `ASSERT_IMPL(a_disp_seen, i_clk, i_rst_n, o_cmd.exec && o_cmd.load, 1'b0, "load in exec")
    `ASSERT_NEXT(a_op_hold, i_clk, i_rst_n, o_cmd.exec, $stable(i_stat.is_dispatch), "op moved")
endmodule
`default_nettype wire

// ----- src/dfios_dp.sv -----
// ----------------------------------------------------------------------------
// dfios_dp
// Queue memory, pointers, counters, config registers and dispatch choice.
// ----------------------------------------------------------------------------
`default_nettype none
module dfios_dp #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TAG_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire dfios_pkg::t_cmd      i_cmd,
    output dfios_pkg::t_stat          o_stat,
    input  wire                       i_op,
    input  wire                       i_sync,
    input  wire                       i_write,
    input  wire [TAG_BITS-1:0]        i_tag,
    input  wire [31:0]                i_now,
    input  wire                       i_cfg_we,
    input  wire [2:0]                 i_cfg_idx,
    input  wire [30:0]                i_cfg_data,
    output logic [1:0]                o_status,
    output logic [TAG_BITS-1:0]       o_tag,
    output logic                      o_sync,
    output logic                      o_write,
    output logic                      o_expired
);
    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = TAG_BITS + 32;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [15:0] CMAX = 16'hFFFF;

    // one memory per class, tag in the high bits, deadline low
    logic [EW-1:0] r_mem0 [QUEUE_DEPTH];
    logic [EW-1:0] r_mem1 [QUEUE_DEPTH];
    logic [EW-1:0] r_mem2 [QUEUE_DEPTH];
    logic [EW-1:0] r_mem3 [QUEUE_DEPTH];
    logic [EW-1:0] r_rd [4];

    logic [PW-1:0] r_head [4];
    logic [PW-1:0] r_tail [4];
    logic [CW-1:0] r_cnt [4];
    logic [15:0] r_batch, r_wst, r_ast;
    logic [30:0] r_exp [4];
    logic [15:0] r_blim, r_wlim, r_alim;

    logic r_op, r_sync, r_write;
    logic [TAG_BITS-1:0] r_tag;
    logic [31:0] r_now;

    assign o_stat.is_dispatch = r_op;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_sync <= i_sync;
            r_write <= i_write;
            r_tag <= i_tag;
            r_now <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp[dfios_pkg::CLS_SYNC_READ] <= 31'd30;
            r_exp[dfios_pkg::CLS_SYNC_WRITE] <= 31'd276;
            r_exp[dfios_pkg::CLS_ASYNC_READ] <= 31'd400;
            r_exp[dfios_pkg::CLS_ASYNC_WRITE] <= 31'd1600;
            r_blim <= 16'd1;
            r_wlim <= 16'd2;
            r_alim <= 16'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dfios_pkg::CFG_SR_EXP: r_exp[dfios_pkg::CLS_SYNC_READ] <= i_cfg_data;
                dfios_pkg::CFG_SW_EXP: r_exp[dfios_pkg::CLS_SYNC_WRITE] <= i_cfg_data;
                dfios_pkg::CFG_AR_EXP: r_exp[dfios_pkg::CLS_ASYNC_READ] <= i_cfg_data;
                dfios_pkg::CFG_AW_EXP: r_exp[dfios_pkg::CLS_ASYNC_WRITE] <= i_cfg_data;
                dfios_pkg::CFG_BATCH: r_blim <= i_cfg_data[15:0];
                dfios_pkg::CFG_WSTARVE: r_wlim <= i_cfg_data[15:0];
                dfios_pkg::CFG_ARSTARVE: r_alim <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // head read during load cycle: pointers are stable then
    always_ff @(posedge i_clk) begin
        r_rd[0] <= r_mem0[r_head[0]];
        r_rd[1] <= r_mem1[r_head[1]];
        r_rd[2] <= r_mem2[r_head[2]];
        r_rd[3] <= r_mem3[r_head[3]];
    end

    // decision
    logic [1:0] a_cls;
    logic [31:0] a_dl;
    logic a_full;
    logic [3:0] ne, expd;
    logic [1:0] d_cls;
    logic d_found, d_exp, d_batch, wr, clr_ast, inc_ast;

    always_comb begin
        logic [31:0] diff;
        logic s_ok;
        logic [1:0] s, a, so, ao;
        a_cls = {r_sync, r_write};
        a_dl = r_now + {1'b0, r_exp[a_cls]};
        a_full = (r_cnt[a_cls] >= FULL);
        for (int k = 0; k < 4; k++) begin
            ne[k] = (r_cnt[k] != '0);
            diff = r_rd[k][31:0] - r_now;
            expd[k] = ne[k] & diff[31];
        end
        d_batch = (r_batch > r_blim);
        d_found = 1'b0;
        d_exp = 1'b0;
        d_cls = dfios_pkg::CLS_ASYNC_READ;
        clr_ast = 1'b0;
        inc_ast = 1'b0;
        wr = (r_wst > r_wlim);
        s = {1'b1, wr};
        a = {1'b0, wr};
        so = {1'b1, ~wr};
        ao = {1'b0, ~wr};
        s_ok = wr || (r_ast <= r_alim);
        if (d_batch && expd[dfios_pkg::CLS_ASYNC_WRITE]) begin
            d_found = 1'b1; d_exp = 1'b1; d_cls = dfios_pkg::CLS_ASYNC_WRITE;
        end else if (d_batch && expd[dfios_pkg::CLS_ASYNC_READ]) begin
            d_found = 1'b1; d_exp = 1'b1; d_cls = dfios_pkg::CLS_ASYNC_READ;
            clr_ast = 1'b1;
        end else if (d_batch && expd[dfios_pkg::CLS_SYNC_WRITE]) begin
            d_found = 1'b1; d_exp = 1'b1; d_cls = dfios_pkg::CLS_SYNC_WRITE;
        end else if (d_batch && expd[dfios_pkg::CLS_SYNC_READ]) begin
            d_found = 1'b1; d_exp = 1'b1; d_cls = dfios_pkg::CLS_SYNC_READ;
        end else if (ne[s] && s_ok) begin
            d_found = 1'b1; d_cls = s;
            inc_ast = !wr && ne[dfios_pkg::CLS_ASYNC_READ];
        end else if (ne[a]) begin
            d_found = 1'b1; d_cls = a;
            clr_ast = !wr;
        end else if (ne[so]) begin
            d_found = 1'b1; d_cls = so;
        end else if (ne[ao]) begin
            d_found = 1'b1; d_cls = ao;
        end
    end

    logic [3:0] wpend;
    always_comb begin
        for (int k = 0; k < 4; k++)
            wpend[k] = (k[1:0] == d_cls) ? (r_cnt[k] > CW'(1)) : ne[k];
    end

    logic do_add, do_pop;
    assign do_add = i_cmd.exec && !r_op && !a_full;
    assign do_pop = i_cmd.exec && r_op && d_found;

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            unique case (a_cls)
                dfios_pkg::CLS_ASYNC_READ: r_mem0[r_tail[0]] <= {r_tag, a_dl};
                dfios_pkg::CLS_ASYNC_WRITE: r_mem1[r_tail[1]] <= {r_tag, a_dl};
                dfios_pkg::CLS_SYNC_READ: r_mem2[r_tail[2]] <= {r_tag, a_dl};
                default: r_mem3[r_tail[3]] <= {r_tag, a_dl};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k] <= '0;
            end
            r_batch <= '0;
            r_wst <= '0;
            r_ast <= '0;
        end else if (i_cmd.exec) begin
            if (do_add) begin
                r_tail[a_cls] <= (r_tail[a_cls] == LAST) ? '0 : r_tail[a_cls] + PW'(1);
                r_cnt[a_cls] <= r_cnt[a_cls] + CW'(1);
            end
            if (r_op) begin
                if (d_batch) r_batch <= '0;
                if (clr_ast) r_ast <= '0;
                else if (inc_ast && r_ast != CMAX) r_ast <= r_ast + 16'd1;
                if (d_found) begin
                    r_head[d_cls] <= (r_head[d_cls] == LAST) ? '0 : r_head[d_cls] + PW'(1);
                    r_cnt[d_cls] <= r_cnt[d_cls] - CW'(1);
                    if (d_batch) r_batch <= 16'd1;
                    else if (r_batch != CMAX) r_batch <= r_batch + 16'd1;
                    if (d_cls[0]) r_wst <= '0;
                    else if ((wpend[dfios_pkg::CLS_SYNC_WRITE] ||
                              wpend[dfios_pkg::CLS_ASYNC_WRITE]) && r_wst != CMAX)
                        r_wst <= r_wst + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_tag <= '0; o_sync <= 1'b0; o_write <= 1'b0; o_expired <= 1'b0;
            if (!r_op) o_status <= a_full ? dfios_pkg::ST_DROPPED : dfios_pkg::ST_ADDED;
            else if (!d_found) o_status <= dfios_pkg::ST_EMPTY;
            else begin
                o_status <= dfios_pkg::ST_DISPATCHED;
                o_tag <= r_rd[d_cls][EW-1:32];
                o_sync <= d_cls[1];
                o_write <= d_cls[0];
                o_expired <= d_exp;
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/deadline_fifo_io_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// deadline_fifo_io_scheduler_unit
// Four-class deadline FIFO I/O scheduler with add and dispatch items.
// ----------------------------------------------------------------------------
// channel | dir | signals
// s_axis  | in  | tdata {now, request_tag, is_write, is_sync}, tuser operation
// m_axis  | out | tdata {out_expired, out_write, out_sync, out_tag, status}
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// An item is captured together with the FIFO head read, then decided and updated.
// Next item can be accepted in the cycle the result is taken.
// Synchronous active-low reset clears pointers, counts and counters; the queue
// memory needs no clearing. A stalled result holds and blocks new items.
`default_nettype none
module deadline_fifo_io_scheduler_unit #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TAG_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] is_sync, [1] is_write, [TAG_BITS+1:2] request_tag, then now
    input  wire [((TAG_BITS+34+7)/8)*8-1:0] s_axis_tdata,
    // [0] operation
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [1:0] status, [TAG_BITS+1:2] out_tag, out_sync, out_write, out_expired
    output logic [((TAG_BITS+5+7)/8)*8-1:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [30:0]  i_cfg_data
);
    localparam int unsigned OW = ((TAG_BITS + 5 + 7) / 8) * 8;
    dfios_pkg::t_cmd w_cmd;
    dfios_pkg::t_stat w_stat;
    logic [1:0] w_status;
    logic [TAG_BITS-1:0] w_tag;
    logic w_sync, w_write, w_exp;

    dfios_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_ready(m_axis_tready), .i_stat(w_stat),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    dfios_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_op(s_axis_tuser), .i_sync(s_axis_tdata[0]), .i_write(s_axis_tdata[1]),
        .i_tag(s_axis_tdata[TAG_BITS+1:2]), .i_now(s_axis_tdata[TAG_BITS+33:TAG_BITS+2]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_status(w_status), .o_tag(w_tag), .o_sync(w_sync), .o_write(w_write),
        .o_expired(w_exp)
    );

    assign m_axis_tdata = OW'({w_exp, w_write, w_sync, w_tag, w_status});
endmodule
`default_nettype wire
